// ===== rtl/cbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbaf_pkg: shared types and constants of the clipped block average filter
// Item and result structs, block descriptor, register codes, back-end states.
// ----------------------------------------------------------------------------
package cbaf_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int COUNT_W          = 7;
    localparam int MAX_SAMPLES_DEF  = 16;

    localparam logic [SAMPLE_W-1:0] NOISE_WINDOW_RST = 12'h030;
    localparam logic [SAMPLE_W-1:0] SEED_FLOOR_RST   = 12'd100;

    typedef enum logic [0:0] {
        REG_NOISE_WINDOW = 1'b0,
        REG_SEED_FLOOR   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] voltage;
        logic [COUNT_W-1:0]  kept_count;
        logic                updated;
        logic                overflow;
    } out_item_t;

    // One closed block handed from the loader to the averaging pass
    typedef struct packed {
        logic                bank;
        logic [COUNT_W-1:0]  len;
        logic [SAMPLE_W-1:0] seed;
        logic                overflow;
    } block_desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_USE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } back_state_t;

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// ===== rtl/cbaf_ram.sv =====
// ----------------------------------------------------------------------------
// cbaf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cbaf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cbaf_front.sv =====
// ----------------------------------------------------------------------------
// cbaf_front: sample loader and seed search
// Writes samples into the current store bank, tracks the seed pair and
// hands a descriptor of each closed block to the queue.
// ----------------------------------------------------------------------------
module cbaf_front #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  cbaf_pkg::in_item_t                 in_data,
    input  logic [cbaf_pkg::SAMPLE_W-1:0]      noise_window,
    input  logic [cbaf_pkg::SAMPLE_W-1:0]      seed_floor,
    input  logic                               q_full,
    output logic                               push,
    output cbaf_pkg::block_desc_t              push_desc,
    output logic                               ram_we,
    output logic [$clog2(MAX_SAMPLES):0]       ram_waddr,
    output logic [cbaf_pkg::SAMPLE_W-1:0]      ram_wdata
);
    import cbaf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int FILL_W = $clog2(MAX_SAMPLES + 1);

    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SAMPLE_W-1:0] seed_reg, seed_next;
    logic                locked_reg, locked_next;
    logic                ovf_reg, ovf_next;
    logic                bank_reg, bank_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;

    logic                accept;
    logic                full;
    logic [FILL_W-1:0]   fill_upd;
    logic [SAMPLE_W-1:0] seed_upd;
    logic                locked_upd;
    logic                ovf_upd;

    assign full     = (fill_reg == FILL_W'(MAX_SAMPLES));
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    assign ram_we    = accept & ~full;
    assign ram_waddr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign ram_wdata = in_data.sample;

    always_comb
    begin
        fill_upd   = fill_reg;
        seed_upd   = seed_reg;
        locked_upd = locked_reg;
        ovf_upd    = ovf_reg;
        prev_next  = prev_reg;
        if (accept)
        begin
            if (!full)
            begin
                if ((fill_reg != '0) && !locked_reg &&
                    (abs_diff(prev_reg, in_data.sample) <= noise_window))
                begin
                    seed_upd = prev_reg;
                    if (prev_reg > seed_floor)
                    begin
                        locked_upd = 1'b1;
                    end
                end
                prev_next = in_data.sample;
                fill_upd  = fill_reg + 1'b1;
            end
            else
            begin
                ovf_upd = 1'b1;
            end
        end
    end

    always_comb
    begin
        push               = accept & in_data.last;
        push_desc.bank     = bank_reg;
        push_desc.len      = COUNT_W'(fill_upd);
        push_desc.seed     = seed_upd;
        push_desc.overflow = ovf_upd;

        fill_next   = fill_upd;
        seed_next   = seed_upd;
        locked_next = locked_upd;
        ovf_next    = ovf_upd;
        bank_next   = bank_reg;
        // close the block: start fresh in the other bank
        if (push)
        begin
            fill_next   = '0;
            seed_next   = '0;
            locked_next = 1'b0;
            ovf_next    = 1'b0;
            bank_next   = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            seed_reg   <= '0;
            locked_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            seed_reg   <= seed_next;
            locked_reg <= locked_next;
            ovf_reg    <= ovf_next;
            bank_reg   <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

endmodule

// ===== rtl/cbaf_queue.sv =====
// ----------------------------------------------------------------------------
// cbaf_queue: single-entry descriptor queue
// Decouples the loader from the averaging pass.
// ----------------------------------------------------------------------------
module cbaf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cbaf_pkg::block_desc_t push_desc,
    output logic                  full,
    output logic                  valid,
    output cbaf_pkg::block_desc_t desc,
    input  logic                  pop
);
    import cbaf_pkg::*;

    logic        valid_reg, valid_next;
    block_desc_t desc_reg, desc_next;

    always_comb
    begin
        valid_next = push | (valid_reg & ~pop);
        desc_next  = push ? push_desc : desc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign full  = valid_reg;
    assign valid = valid_reg;
    assign desc  = desc_reg;

endmodule

// ===== rtl/cbaf_back.sv =====
// ----------------------------------------------------------------------------
// cbaf_back: averaging pass and divider
// Walks the stored block from the seed, sums and counts the kept samples,
// divides with a restoring divider when the voltage is refreshed and presents one result per block.
// ----------------------------------------------------------------------------
module cbaf_back #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  cbaf_pkg::block_desc_t              q_desc,
    output logic                               pop,
    input  logic [cbaf_pkg::SAMPLE_W-1:0]      noise_window,
    output logic [$clog2(MAX_SAMPLES):0]       ram_raddr,
    input  logic [cbaf_pkg::SAMPLE_W-1:0]      ram_rdata,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cbaf_pkg::out_item_t                out_data
);
    import cbaf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int FILL_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int REM_W  = FILL_W + 1;

    back_state_t         state_reg, state_next;

    logic                bank_reg, bank_next;
    logic [FILL_W-1:0]   len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic [SAMPLE_W-1:0] ref_reg, ref_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [FILL_W-1:0]   cnt_reg, cnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    out_item_t           out_reg, out_next;

    logic                hit;
    logic                last_idx;
    logic                upd;
    logic [REM_W-1:0]    rem_sh;
    logic                qbit;
    logic [SUM_W-1:0]    quo_step;

    assign hit      = (abs_diff(ram_rdata, ref_reg) <= noise_window);
    assign last_idx = ((idx_reg + 1'b1) == len_reg);
    assign upd      = (cnt_reg != '0) && (cnt_reg >= (len_reg >> 1));
    assign rem_sh   = {rem_reg[FILL_W-1:0], quo_reg[SUM_W-1]};
    assign qbit     = (rem_sh >= REM_W'(cnt_reg));
    assign quo_step = {quo_reg[SUM_W-2:0], qbit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_USE;
            ST_USE:   state_next = last_idx ? ST_EVAL : ST_ISSUE;
            ST_EVAL:  state_next = upd ? ST_DIV : ST_OUT;
            ST_DIV:   if (dcnt_reg == '0) state_next = ST_OUT;
            ST_OUT:   if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bank_next = bank_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        idx_next  = idx_reg;
        ref_next  = ref_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        dcnt_next = dcnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        held_next = held_reg;
        out_next  = out_reg;
        pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop       = 1'b1;
                    bank_next = q_desc.bank;
                    len_next  = FILL_W'(q_desc.len);
                    ovf_next  = q_desc.overflow;
                    ref_next  = q_desc.seed;
                    idx_next  = '0;
                    sum_next  = '0;
                    cnt_next  = '0;
                end
            end
            ST_ISSUE:
            begin
            end
            ST_USE:
            begin
                if (hit)
                begin
                    sum_next = sum_reg + SUM_W'(ram_rdata);
                    ref_next = ram_rdata;
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_EVAL:
            begin
                quo_next  = sum_reg;
                rem_next  = '0;
                dcnt_next = DCNT_W'(SUM_W - 1);
                out_next.voltage    = held_reg;
                out_next.kept_count = COUNT_W'(cnt_reg);
                out_next.updated    = upd;
                out_next.overflow   = ovf_reg;
            end
            ST_DIV:
            begin
                rem_next  = qbit ? (rem_sh - REM_W'(cnt_reg)) : rem_sh;
                quo_next  = quo_step;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    held_next        = quo_step[SAMPLE_W-1:0];
                    out_next.voltage = quo_step[SAMPLE_W-1:0];
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign ram_raddr = {bank_reg, idx_reg[IDX_W-1:0]};
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        len_reg  <= len_next;
        ovf_reg  <= ovf_next;
        idx_reg  <= idx_next;
        ref_reg  <= ref_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        dcnt_reg <= dcnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
    end

endmodule

// ===== rtl/clipped_block_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// clipped_block_average_filter_unit: limiting average filter over ADC blocks
// Loads a block of samples, picks a seed, averages the samples that track
// within the noise window and holds the result voltage.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer when
//  in        in_valid, in_stall, in_data      input      in_valid & !in_stall
//  out       out_valid, out_stall, out_data   output     out_valid & !out_stall
//  cfg       cfg_valid, cfg_ready, cfg_index,  input      cfg_valid & cfg_ready
//            cfg_data
//
// The loader takes one sample per cycle while in_stall is low, into one of
// two store banks. A closed block is then taken from the queue, each stored
// sample is read and checked in the averaging pass, then come an evaluate
// step, the divider when the voltage is refreshed, and an output step.
// in_stall rises while a closed block waits for the averaging pass; the
// pass holds its result until out_stall drops. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module clipped_block_average_filter_unit #(
    parameter int MAX_SAMPLES = cbaf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cbaf_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cbaf_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cbaf_pkg::cfg_reg_t            cfg_index,
    input  logic [cbaf_pkg::SAMPLE_W-1:0] cfg_data
);
    import cbaf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SAMPLES) + 1;

    logic [SAMPLE_W-1:0] noise_window_reg, noise_window_next;
    logic [SAMPLE_W-1:0] seed_floor_reg, seed_floor_next;

    logic                push;
    block_desc_t         push_desc;
    logic                q_full;
    logic                q_valid;
    block_desc_t         q_desc;
    logic                pop;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        noise_window_next = noise_window_reg;
        seed_floor_next   = seed_floor_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NOISE_WINDOW: noise_window_next = cfg_data;
                REG_SEED_FLOOR:   seed_floor_next   = cfg_data;
                default:          noise_window_next = noise_window_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_window_reg <= NOISE_WINDOW_RST;
            seed_floor_reg   <= SEED_FLOOR_RST;
        end
        else
        begin
            noise_window_reg <= noise_window_next;
            seed_floor_reg   <= seed_floor_next;
        end
    end

    cbaf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (1 << ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cbaf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .noise_window (noise_window_reg),
        .seed_floor   (seed_floor_reg),
        .q_full       (q_full),
        .push         (push),
        .push_desc    (push_desc),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    cbaf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .valid     (q_valid),
        .desc      (q_desc),
        .pop       (pop)
    );

    cbaf_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_desc       (q_desc),
        .pop          (pop),
        .noise_window (noise_window_reg),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

// ===== test/tb_clipped_block_average_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_block_average_filter_unit: self-checking bench of the filter
// Feeds sample blocks (directed corner cases, then random blocks around a
// moving level with outliers and overflowing blocks) under several register
// settings and idle patterns. It predicts each block's reading and compares
// every output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_clipped_block_average_filter_unit;
    import cbaf_pkg::*;

    localparam int STORE_DEPTH   = MAX_SAMPLES_DEF;
    // margin over averaging pass, evaluate, divider and output of one full block
    localparam int SETTLE_CYCLES = 2 * (2 * STORE_DEPTH + 1 + SAMPLE_W + 4 + 1);
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 325;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_reg_t            cfg_index = REG_NOISE_WINDOW;
    logic [SAMPLE_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    // predicted filter state
    logic [SAMPLE_W-1:0] noise_window = NOISE_WINDOW_RST;
    logic [SAMPLE_W-1:0] seed_floor = SEED_FLOOR_RST;
    logic [SAMPLE_W-1:0] block_store [STORE_DEPTH];
    int unsigned         fill_level = 0;
    logic [SAMPLE_W-1:0] seed_level = '0;
    bit                  seed_fixed = 1'b0;
    logic [SAMPLE_W-1:0] held_level = '0;
    bit                  store_overrun = 1'b0;

    out_item_t expected_readings [$];

    clipped_block_average_filter_unit #(
        .MAX_SAMPLES (STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [SAMPLE_W-1:0] distance(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Advance the predicted state by one sample; a closing sample yields a reading.
    function automatic void absorb_sample(input in_item_t item);
        logic [SAMPLE_W-1:0] track;
        int unsigned         total;
        int unsigned         kept;
        int unsigned         len;
        bit                  refresh;
        out_item_t           reading;
        if (fill_level < STORE_DEPTH)
        begin
            if (fill_level > 0 && !seed_fixed &&
                distance(block_store[fill_level-1], item.sample) <= noise_window)
            begin
                seed_level = block_store[fill_level-1];
                if (seed_level > seed_floor)
                    seed_fixed = 1'b1;
            end
            block_store[fill_level] = item.sample;
            fill_level++;
        end
        else
            store_overrun = 1'b1;
        if (!item.last)
            return;
        len   = fill_level;
        track = seed_level;
        total = 0;
        kept  = 0;
        for (int i = 0; i < len; i++)
        begin
            if (distance(block_store[i], track) <= noise_window)
            begin
                total += block_store[i];
                track  = block_store[i];
                kept++;
            end
        end
        refresh = (kept != 0) && (kept >= len / 2);
        if (refresh)
            held_level = SAMPLE_W'(total / kept);
        reading.voltage    = held_level;
        reading.kept_count = COUNT_W'(kept);
        reading.updated    = refresh;
        reading.overflow   = store_overrun;
        expected_readings.push_back(reading);
        fill_level    = 0;
        seed_level    = '0;
        seed_fixed    = 1'b0;
        store_overrun = 1'b0;
    endfunction

    always @(posedge clk)
    begin : check_readings
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected reading voltage=%0d kept=%0d upd=%0b ovf=%0b",
                             $realtime, out_data.voltage, out_data.kept_count,
                             out_data.updated, out_data.overflow);
                mismatch_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (out_data.voltage !== want.voltage ||
                    out_data.kept_count !== want.kept_count ||
                    out_data.updated !== want.updated ||
                    out_data.overflow !== want.overflow)
                begin
                    if (mismatch_count < 10)
                        $display(
                            "%0t: mismatch expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                            $realtime,
                            want.voltage, want.kept_count, want.updated, want.overflow,
                            out_data.voltage, out_data.kept_count,
                            out_data.updated, out_data.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_sample(input int value, input bit closes);
        int       gap;
        in_item_t item;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.sample = SAMPLE_W'(value);
        item.last   = closes;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_sample(item);
    endtask

    task automatic send_block(input int values [$]);
        foreach (values[i])
            send_sample(values[i], i == values.size() - 1);
    endtask

    task automatic write_register(input cfg_reg_t index, input logic [SAMPLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            REG_NOISE_WINDOW: noise_window = value;
            REG_SEED_FLOOR:   seed_floor   = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold input idle until every reading is back and the back end has drained.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One block around a random level, with repeats, outliers and overruns.
    task automatic send_random_block(output int sent);
        int len;
        int level;
        int spread;
        int value;
        int prev;
        int pick;
        bit noisy;
        pick = $urandom_range(99);
        if (pick < 8)
            len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
        else if (pick < 20)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(4, STORE_DEPTH);
        pick = $urandom_range(99);
        if (pick < 8)
            level = $urandom_range(0, 40);
        else if (pick < 16)
            level = $urandom_range(4055, 4095);
        else
            level = $urandom_range(4095);
        spread = int'(noise_window) + int'(noise_window) / 2 + 2;
        if (spread > 4095)
            spread = 4095;
        noisy = ($urandom_range(99) < 15);
        prev  = level;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (noisy || pick < 10)
                value = $urandom_range(4095);
            else if (pick < 25)
                value = prev;
            else
                value = level + $urandom_range(0, 2 * spread) - spread;
            if (value < 0)
                value = 0;
            if (value > 4095)
                value = 4095;
            send_sample(value, i == len - 1);
            prev = value;
        end
        sent = len;
    endtask

    task automatic run_random_blocks(input logic [SAMPLE_W-1:0] window,
                                     input logic [SAMPLE_W-1:0] floor_level);
        int total;
        int sent;
        write_register(REG_NOISE_WINDOW, window);
        write_register(REG_SEED_FLOOR, floor_level);
        total = 0;
        while (total < PHASE_ITEMS)
        begin
            send_random_block(sent);
            total += sent;
        end
        wait_idle();
    endtask

    task automatic test_directed_cases();
        int overrun [$];
        send_idle_pct = 26;
        recv_idle_pct = 56;
        send_block('{2500});                    // lone sample: no pair, seed stays zero
        send_block('{4095, 4095, 0, 0});        // field extremes, seed locks high
        send_block('{50, 60, 3000});            // pair below the floor: fallback seed
        send_block('{1000, 3000});              // nothing tracks the zero seed
        send_block('{0, 2000, 4000});           // only the zero sample tracks
        for (int i = 0; i < STORE_DEPTH + 1; i++)
            overrun.push_back(1800 + 4 * i);    // closing sample is dropped
        send_block(overrun);
        wait_idle();
    endtask

    task automatic test_default_registers();
        send_idle_pct = 26;
        recv_idle_pct = 56;
        run_random_blocks(NOISE_WINDOW_RST, SEED_FLOOR_RST);
    endtask

    task automatic test_closed_window();
        send_idle_pct = 26;
        recv_idle_pct = 56;
        run_random_blocks('0, '1);
    endtask

    task automatic test_open_window();
        send_idle_pct = 56;
        recv_idle_pct = 26;
        run_random_blocks('1, '0);
    endtask

    task automatic test_narrow_window_high_floor();
        send_idle_pct = 56;
        recv_idle_pct = 26;
        run_random_blocks(12'd16, 12'd2000);
    endtask

    task automatic test_random_registers();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_blocks(SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
        run_random_blocks(SAMPLE_W'($urandom_range(0, 200)), SAMPLE_W'($urandom_range(4095)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_default_registers();
        test_closed_window();
        test_open_window();
        test_narrow_window_high_floor();
        test_random_registers();
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cbaf_pkg.sv
rtl/cbaf_ram.sv
rtl/cbaf_front.sv
rtl/cbaf_queue.sv
rtl/cbaf_back.sv
rtl/clipped_block_average_filter_unit.sv
test/tb_clipped_block_average_filter_unit.sv
